[rtl/mcusa_pkg.sv]
package mcusa_pkg;

  localparam int unsigned BlockSize     = 8;
  localparam int unsigned MaxFactor     = 4;
  localparam int unsigned NumComponents = 3;

  localparam logic [2:0] REG_MCUS_PER_ROW = 3'd0;
  localparam logic [2:0] REG_H_FACTOR_0   = 3'd1;
  localparam logic [2:0] REG_V_FACTOR_0   = 3'd2;
  localparam logic [2:0] REG_H_FACTOR_1   = 3'd3;
  localparam logic [2:0] REG_V_FACTOR_1   = 3'd4;
  localparam logic [2:0] REG_H_FACTOR_2   = 3'd5;
  localparam logic [2:0] REG_V_FACTOR_2   = 3'd6;

  // ceil(2^15 / 3), exact for dividends below 2^15
  localparam logic [13:0] Recip3 = 14'd10923;

  typedef struct packed {
    logic [15:0] x_coord;
    logic [15:0] y_coord;
  } req_t;

  typedef struct packed {
    logic [25:0] mcu_index;
    logic [3:0]  block_0;
    logic [5:0]  sample_0;
    logic [3:0]  block_1;
    logic [5:0]  sample_1;
    logic [3:0]  block_2;
    logic [5:0]  sample_2;
  } res_t;

  typedef struct packed {
    logic [13:0]                   mcus_per_row;
    logic [NumComponents-1:0][2:0] h_eff;
    logic [NumComponents-1:0][2:0] v_eff;
    logic [2:0]                    hmax;
    logic [2:0]                    vmax;
  } cfg_t;

  function automatic logic [2:0] eff_factor(input logic [2:0] raw);
    if (raw == 3'd0) begin
      return 3'd1;
    end else if (raw > 3'(MaxFactor)) begin
      return 3'(MaxFactor);
    end
    return raw;
  endfunction

  // divide by a sampling factor in 1..4
  function automatic logic [12:0] div_fac(input logic [12:0] v, input logic [2:0] d);
    logic [26:0] p;
    p = 27'(v) * 27'(Recip3);
    case (d)
      3'd2:    return v >> 1;
      3'd3:    return {1'b0, p[26:15]};
      3'd4:    return v >> 2;
      default: return v;
    endcase
  endfunction

endpackage

[rtl/jpeg_mcu_sample_address_top.sv]
// JPEG MCU / block / sample address generator.
// Request channel: req_i carries a pixel (x_coord, y_coord); it is taken at
// a rising edge with start high and busy low. busy is always low, so one
// request can be taken every clock.
// Result channel: res_o holds mcu_index and, per component, the block within
// the MCU and the sample within that block. res_strobe_o marks it for one
// cycle; the receiver takes it then and cannot hold it off.
// Throughput: 1 request per clock.
// Stage 1 divides the pixel position by the MCU size, stage 2 forms the
// in-MCU offset and the row product, stage 3 adds the column and maps each
// component onto its blocks.
// Config: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0 MCUs per
// row, 1..6 h/v sampling factors per component); other indexes are ignored.
// Write only while no request is in flight.
// Reset: pipeline emptied, MCUs per row and all factors set to 1.
module jpeg_mcu_sample_address_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  mcusa_pkg::req_t  req_i,
  output logic             res_strobe_o,
  output mcusa_pkg::res_t  res_o,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [13:0]      cfg_wdata_i
);
  import mcusa_pkg::*;

  cfg_t cfg;

  logic        v1_q, v2_q, v3_q;
  logic [15:0] x1_q, y1_q;
  logic [12:0] qx1_q, qy1_q;
  logic [12:0] qx2_q;
  logic [25:0] prod2_q;
  logic [4:0]  px2_q, py2_q;
  logic [25:0] mcu_index_q;
  logic [12:0] remx, remy;
  logic [26:0] prod;
  logic        accept;

  logic [NumComponents-1:0][3:0] blk;
  logic [NumComponents-1:0][5:0] smp;

  mcusa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // stage 1: MCU column / row
  always_ff @(posedge clk_i) begin
    x1_q  <= req_i.x_coord;
    y1_q  <= req_i.y_coord;
    qx1_q <= div_fac(req_i.x_coord[15:3], cfg.hmax);
    qy1_q <= div_fac(req_i.y_coord[15:3], cfg.vmax);
  end

  // stage 2: offset within MCU, row product
  always_comb begin
    remx = x1_q[15:3] - 13'(qx1_q * cfg.hmax);
    remy = y1_q[15:3] - 13'(qy1_q * cfg.vmax);
    prod = 27'(qy1_q) * 27'(cfg.mcus_per_row);
  end

  always_ff @(posedge clk_i) begin
    qx2_q   <= qx1_q;
    prod2_q <= prod[25:0];
    px2_q   <= {remx[1:0], x1_q[2:0]};
    py2_q   <= {remy[1:0], y1_q[2:0]};
  end

  // stage 3
  always_ff @(posedge clk_i) begin
    mcu_index_q <= prod2_q + 26'(qx2_q);
  end

  for (genvar c = 0; c < NumComponents; c++) begin : g_comp
    mcusa_comp u_comp (
      .clk_i    (clk_i),
      .px_i     (px2_q),
      .py_i     (py2_q),
      .h_i      (cfg.h_eff[c]),
      .v_i      (cfg.v_eff[c]),
      .hmax_i   (cfg.hmax),
      .vmax_i   (cfg.vmax),
      .block_o  (blk[c]),
      .sample_o (smp[c])
    );
  end

  assign res_strobe_o     = v3_q;
  assign res_o.mcu_index  = mcu_index_q;
  assign res_o.block_0    = blk[0];
  assign res_o.sample_0   = smp[0];
  assign res_o.block_1    = blk[1];
  assign res_o.sample_1   = smp[1];
  assign res_o.block_2    = blk[2];
  assign res_o.sample_2   = smp[2];

  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 res_strobe_o)
    else $error("request lost in pipeline");

  a_res_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> $past(accept, 3))
    else $error("result without request");

  a_busy_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v1_q |-> $past(start))
    else $error("stage 1 valid without start");

endmodule

[rtl/mcusa_cfg.sv]
module mcusa_cfg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [13:0]      cfg_wdata_i,
  output mcusa_pkg::cfg_t  cfg_o
);
  import mcusa_pkg::*;

  logic [13:0]                   mpr_q;
  logic [NumComponents-1:0][2:0] h_q;
  logic [NumComponents-1:0][2:0] v_q;
  logic [2:0]                    hmax, vmax;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpr_q <= 14'd1;
      h_q   <= {NumComponents{3'd1}};
      v_q   <= {NumComponents{3'd1}};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MCUS_PER_ROW: mpr_q  <= cfg_wdata_i;
        REG_H_FACTOR_0:   h_q[0] <= cfg_wdata_i[2:0];
        REG_V_FACTOR_0:   v_q[0] <= cfg_wdata_i[2:0];
        REG_H_FACTOR_1:   h_q[1] <= cfg_wdata_i[2:0];
        REG_V_FACTOR_1:   v_q[1] <= cfg_wdata_i[2:0];
        REG_H_FACTOR_2:   h_q[2] <= cfg_wdata_i[2:0];
        REG_V_FACTOR_2:   v_q[2] <= cfg_wdata_i[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hmax = 3'd1;
    vmax = 3'd1;
    for (int c = 0; c < NumComponents; c++) begin
      cfg_o.h_eff[c] = eff_factor(h_q[c]);
      cfg_o.v_eff[c] = eff_factor(v_q[c]);
      if (cfg_o.h_eff[c] > hmax) begin
        hmax = cfg_o.h_eff[c];
      end
      if (cfg_o.v_eff[c] > vmax) begin
        vmax = cfg_o.v_eff[c];
      end
    end
    cfg_o.mcus_per_row = mpr_q;
    cfg_o.hmax         = hmax;
    cfg_o.vmax         = vmax;
  end

endmodule

[rtl/mcusa_comp.sv]
module mcusa_comp (
  input  logic       clk_i,
  input  logic [4:0] px_i,
  input  logic [4:0] py_i,
  input  logic [2:0] h_i,
  input  logic [2:0] v_i,
  input  logic [2:0] hmax_i,
  input  logic [2:0] vmax_i,
  output logic [3:0] block_o,
  output logic [5:0] sample_o
);
  import mcusa_pkg::*;

  logic [7:0]  xh, yv;
  logic [12:0] cx, cy;
  logic [3:0]  block_d, block_q;
  logic [5:0]  sample_d, sample_q;

  always_comb begin
    xh       = 8'(px_i) * 8'(h_i);
    yv       = 8'(py_i) * 8'(v_i);
    cx       = div_fac(13'(xh), hmax_i);
    cy       = div_fac(13'(yv), vmax_i);
    block_d  = 4'(cy[4:3]) * 4'(h_i) + 4'(cx[4:3]);
    sample_d = {cy[2:0], cx[2:0]};
  end

  always_ff @(posedge clk_i) begin
    block_q  <= block_d;
    sample_q <= sample_d;
  end

  assign block_o  = block_q;
  assign sample_o = sample_q;

endmodule
